### hw/rtl/sabd_pkg.sv
// shared types, constants and helpers for the anchor box decoder
package sabd_pkg;

  localparam int MAX_LEVELS        = 4;
  localparam int ANCHORS_PER_LEVEL = 2;
  localparam int LEVEL_W           = 2;
  localparam int POS_W             = 12;
  localparam int CNT_W             = 20;
  localparam int COORD_W           = 20;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int IN_DATA_W         = 80;
  localparam int OUT_DATA_W        = 120;

  // datapath stages between capture and a settled half extent
  localparam int DP_LATENCY = 8;
  localparam int STEP_W     = 4;

  localparam logic [17:0] LOG2E_Q16 = 18'd94548;
  localparam logic [15:0] EXP_C1    = 16'd43017;
  localparam logic [15:0] EXP_C2    = 16'd22519;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NET_WIDTH   = 3'd0,
    REG_NET_HEIGHT  = 3'd1,
    REG_SCORE_THR   = 3'd2,
    REG_VARIANCES   = 3'd3,
    REG_STRIDES     = 3'd4,
    REG_SIZES_FIRST = 3'd5,
    REG_SIZES_SEC   = 3'd6,
    REG_LEVEL_COUNT = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  typedef struct packed {
    logic capture;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic keep;
  } dp_status_t;

  function automatic logic [15:0] field16(input logic [63:0] packed_v,
                                          input logic [LEVEL_W-1:0] idx);
    return packed_v[16*idx +: 16];
  endfunction

  // zero stride counts as one
  function automatic logic [7:0] stride_sel(input logic [31:0] strides,
                                            input logic [LEVEL_W-1:0] idx);
    logic [7:0] s;
    s = strides[8*idx +: 8];
    return (s == 8'd0) ? 8'd1 : s;
  endfunction

  function automatic logic [COORD_W-1:0] sat20(input logic signed [34:0] v);
    if (v > 35'sd524287) begin
      return 20'h7FFFF;
    end else if (v < -35'sd524288) begin
      return 20'h80000;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

### hw/rtl/sabd_ctrl.sv
// controller: accepts items, sequences the arithmetic, owns the output valid
module sabd_ctrl import sabd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid, out_valid_next;
  logic              accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd.capture  = 1'b0;
    cmd.out_load = 1'b0;
    s_tready     = 1'b0;
    accept       = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        accept      = s_tvalid;
        cmd.capture = accept;
        if (accept && status.keep) begin
          state_next = ST_BUSY;
          step_next  = '0;
        end
      end
      ST_BUSY: begin
        if (step != STEP_W'(DP_LATENCY)) begin
          step_next = step + STEP_W'(1);
        end else if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

endmodule

### hw/rtl/sabd_datapath.sv
// datapath: config registers, anchor grid walk and the fixed-point box arithmetic
module sabd_datapath import sabd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
  input  logic [IN_DATA_W-1:0]   s_tdata,
  input  logic                   s_tuser,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output logic [OUT_DATA_W-1:0]  m_tdata
);

  // configuration
  logic [11:0] net_width, net_height;
  logic [15:0] score_threshold;
  logic [63:0] variances, sizes_first, sizes_second;
  logic [31:0] level_strides;
  logic [2:0]  level_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      net_width       <= 12'd320;
      net_height      <= 12'd320;
      score_threshold <= 16'd32768;
      variances       <= '0;
      level_strides   <= '0;
      sizes_first     <= '0;
      sizes_second    <= '0;
      level_count     <= 3'd1;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_NET_WIDTH:   net_width       <= cfg_wr_data[11:0];
        REG_NET_HEIGHT:  net_height      <= cfg_wr_data[11:0];
        REG_SCORE_THR:   score_threshold <= cfg_wr_data[15:0];
        REG_VARIANCES:   variances       <= cfg_wr_data;
        REG_STRIDES:     level_strides   <= cfg_wr_data[31:0];
        REG_SIZES_FIRST: sizes_first     <= cfg_wr_data;
        REG_SIZES_SEC:   sizes_second    <= cfg_wr_data;
        REG_LEVEL_COUNT: level_count     <= cfg_wr_data[2:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [15:0] in_score;
  assign in_score = s_tdata[15:0];
  assign status.keep = (in_score >= score_threshold);

  // grid walk
  logic [LEVEL_W-1:0] level_index, lv_e;
  logic [POS_W-1:0]   row_position, column_position, row_e, col_e;
  logic               anchor_slot, slot_e;
  logic [CNT_W-1:0]   anchor_counter, cnt_e;
  logic [7:0]         stride_e;
  logic               two_slots;
  logic [15:0]        size_e;
  logic [20:0]        col_span, row_span;
  logic [2:0]         levels_n;

  assign lv_e   = s_tuser ? '0 : level_index;
  assign row_e  = s_tuser ? '0 : row_position;
  assign col_e  = s_tuser ? '0 : column_position;
  assign slot_e = s_tuser ? 1'b0 : anchor_slot;
  assign cnt_e  = s_tuser ? '0 : anchor_counter;

  assign stride_e  = stride_sel(level_strides, lv_e);
  assign two_slots = (ANCHORS_PER_LEVEL > 1) && (field16(sizes_second, lv_e) != 16'd0);
  assign size_e    = (slot_e && two_slots) ? field16(sizes_second, lv_e)
                                           : field16(sizes_first, lv_e);
  assign col_span  = ({1'b0, col_e} + 13'd1) * stride_e;
  assign row_span  = ({1'b0, row_e} + 13'd1) * stride_e;

  always_comb begin
    if (level_count == 3'd0) begin
      levels_n = 3'd1;
    end else if (level_count > 3'(MAX_LEVELS)) begin
      levels_n = 3'(MAX_LEVELS);
    end else begin
      levels_n = level_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_index     <= '0;
      row_position    <= '0;
      column_position <= '0;
      anchor_slot     <= 1'b0;
      anchor_counter  <= '0;
    end else if (cmd.capture) begin
      level_index     <= lv_e;
      row_position    <= row_e;
      column_position <= col_e;
      anchor_slot     <= 1'b0;
      anchor_counter  <= cnt_e + CNT_W'(1);
      if (!slot_e && two_slots) begin
        anchor_slot <= 1'b1;
      end else if (col_span < {9'd0, net_width}) begin
        column_position <= col_e + POS_W'(1);
      end else begin
        column_position <= '0;
        if (row_span < {9'd0, net_height}) begin
          row_position <= row_e + POS_W'(1);
        end else begin
          row_position <= '0;
          if (({1'b0, lv_e} + 3'd1) < levels_n) begin
            level_index <= lv_e + LEVEL_W'(1);
          end else begin
            // end of frame
            level_index    <= '0;
            anchor_counter <= '0;
          end
        end
      end
    end
  end

  // captured item, lane 0 is x / width, lane 1 is y / height
  logic [LEVEL_W-1:0] lv_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [15:0]        score_q, size_q;
  logic [7:0]         stride_q;
  logic [POS_W-1:0]   pos_q [2];
  logic [15:0]        offc_q [2];
  logic [15:0]        offe_q [2];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lv_q      <= lv_e;
      cnt_q     <= cnt_e;
      score_q   <= in_score;
      size_q    <= size_e;
      stride_q  <= stride_e;
      pos_q[0]  <= col_e;
      pos_q[1]  <= row_e;
      offc_q[0] <= s_tdata[31:16];
      offc_q[1] <= s_tdata[47:32];
      offe_q[0] <= s_tdata[63:48];
      offe_q[1] <= s_tdata[79:64];
    end
  end

  logic signed [32:0] pc [2];
  logic signed [32:0] pe [2];
  logic [20:0]        cen [2];
  logic signed [49:0] sc [2];
  logic signed [20:0] t [2];
  logic signed [31:0] ctr [2];
  logic signed [22:0] y [2];
  logic [15:0]        f [2];
  logic [15:0]        f2 [2];
  logic signed [6:0]  k [2];
  logic signed [6:0]  k2 [2];
  logic [17:0]        p [2];
  logic signed [6:0]  k3 [2];
  logic [33:0]        m [2];
  logic [32:0]        h [2];

  logic signed [33:0] te [2];
  logic signed [49:0] sc_rnd [2];
  logic signed [38:0] yp [2];
  logic [31:0]        ff [2];
  logic [32:0]        poly [2];
  logic [3:0]         nk [2];
  logic [45:0]        mw [2];
  logic [45:0]        hw [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      te[i]     = (34'(pe[i]) + 34'sd256) >>> 9;
      sc_rnd[i] = (sc[i] + 50'sd1048576) >>> 21;
      yp[i]     = t[i] * $signed({1'b0, LOG2E_Q16});
      ff[i]     = f[i] * f[i];
      poly[i]   = 33'(EXP_C1) * 33'(f[i]) + 33'(EXP_C2) * 33'(f2[i]);
      nk[i]     = 4'(-k3[i]);
      if (!k3[i][6]) begin
        mw[i] = {12'd0, m[i]} << k3[i][3:0];
        hw[i] = (mw[i] + 46'd4096) >> 13;
      end else begin
        mw[i] = {12'd0, m[i]} + (46'd1 << (5'd12 + 5'(nk[i])));
        hw[i] = mw[i] >> (5'd13 + 5'(nk[i]));
      end
    end
  end

  // arithmetic chain, up to three multiplies per stage in each lane
  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      pc[i]  <= $signed(offc_q[i]) * $signed({1'b0, variances[16*i +: 16]});
      pe[i]  <= $signed(offe_q[i]) * $signed({1'b0, variances[32 + 16*i +: 16]});
      cen[i] <= {pos_q[i], 1'b1} * stride_q;
      sc[i]  <= pc[i] * $signed({1'b0, size_q});
      if (te[i] > 34'sd524288) begin
        t[i] <= 21'sd524288;
      end else if (te[i] < -34'sd524288) begin
        t[i] <= -21'sd524288;
      end else begin
        t[i] <= te[i][20:0];
      end
      ctr[i] <= $signed({8'd0, cen[i], 3'b000}) + $signed(sc_rnd[i][31:0]);
      y[i]   <= 23'((yp[i] + 39'sd32768) >>> 16);
      f[i]   <= y[i][15:0];
      k[i]   <= 7'(y[i] >>> 16);
      f2[i]  <= ff[i][31:16];
      p[i]   <= 18'd65536 + 18'((poly[i] + 33'd32768) >> 16);
      k2[i]  <= k[i];
      m[i]   <= size_q * p[i];
      k3[i]  <= k2[i];
      h[i]   <= hw[i][32:0];
    end
  end

  logic [COORD_W-1:0] lo [2];
  logic [COORD_W-1:0] hi [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      lo[i] = sat20(35'(ctr[i]) - $signed({2'b00, h[i]}));
      hi[i] = sat20(35'(ctr[i]) + $signed({2'b00, h[i]}));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {2'b00, lv_q, cnt_q, score_q, hi[1], hi[0], lo[1], lo[0]};
    end
  end

endmodule

### hw/rtl/ssd_anchor_box_decode.sv
// top level of the ssd anchor box decoder
// Each input item is one anchor's network output; the block tracks level, row, column
// and anchor slot itself, and frame_start restarts that walk. An item whose score is
// under score_threshold is accepted while idle and gives no result. A kept item keeps
// the next item out until it has passed through the eight-stage fixed-point chain
// (offset times variance times size, then the exp approximation), which takes one
// item at a time, and longer while the previous box has not yet been taken; the
// finished box waits in the output register, so the next item is accepted while
// it is still held there. The user must see that config writes are taken only while
// no item is in flight; the block itself does not enforce this.
module ssd_anchor_box_decode import sabd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // score, offset_x, offset_y, offset_w, offset_h
  input  logic [IN_DATA_W-1:0]   s_tdata,
  // frame_start
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // left, top, right, bottom, kept_score, anchor_number, level_number, zero pad
  output logic [OUT_DATA_W-1:0]  m_tdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sabd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sabd_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cmd         (cmd),
    .status      (status),
    .m_tdata     (m_tdata)
  );

endmodule

### hw/rtl/sabd_checker.sv
// port-level checks for the anchor box decoder
module sabd_checker import sabd_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_DATA_W-1:0]  m_tdata
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_x_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[19:0]) <= $signed(m_tdata[59:40]))
    else $error("left beyond right");

  a_y_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[39:20]) <= $signed(m_tdata[79:60]))
    else $error("top beyond bottom");

endmodule

bind ssd_anchor_box_decode sabd_checker u_chk (.*);
